FILE: rtl/pkvbm_pkg.sv
package pkvbm_pkg;

  localparam int unsigned NUM_BLOCKS        = 1024;
  localparam int unsigned MAX_SEQS          = 64;
  localparam int unsigned MAX_PAGES_PER_SEQ = 64;

  localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W  = BLK_W + 1;
  localparam int unsigned SEQ_W  = $clog2(MAX_SEQS);
  localparam int unsigned PG_W   = $clog2(MAX_PAGES_PER_SEQ);
  localparam int unsigned PH_W   = PG_W + 1;
  localparam int unsigned HG_W   = SEQ_W + 1;
  localparam int unsigned PT_AW  = SEQ_W + PG_W;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned TPB_W  = 9;

  typedef enum logic [1:0] {
    REQ_OPEN   = 2'd0,
    REQ_ENSURE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_FREE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_POOL_EMPTY = 3'd1,
    ST_NOT_MAPPED = 3'd2,
    ST_SEQ_FULL   = 3'd3,
    ST_PAGES_FULL = 3'd4
  } status_e;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_res_t;

endpackage

FILE: rtl/pkvbm_div.sv
// Restoring divider, one quotient bit per cycle.
module pkvbm_div
  import pkvbm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [POS_W-1:0] dividend_i,
  input  logic [TPB_W-1:0] divisor_i,
  output div_res_t         res_o
);

  localparam int unsigned CW = $clog2(POS_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [POS_W-1:0] quo_q, quo_d;
  logic [TPB_W-1:0] rem_q, rem_d;
  logic [TPB_W-1:0] dvs_q, dvs_d;
  logic [TPB_W:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[POS_W-1]};
    if (start_i) begin
      // A block size of zero behaves as one.
      dvs_d  = (divisor_i == '0) ? TPB_W'(1) : divisor_i;
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(POS_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = TPB_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[POS_W-2:0], 1'b1};
      end else begin
        rem_d = trial[TPB_W-1:0];
        quo_d = {quo_q[POS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;

endmodule

FILE: rtl/paged_kv_block_manager.sv
// Paged KV-cache block manager.
// Requests arrive on the s_axis stream, one transaction per request, and each
// request yields exactly one result transaction on m_axis. Open hands out a new
// sequence handle; ensure allocates pages for a token position, popping blocks
// from the free stack; look up returns the block that holds a token; free
// pushes every in-use page of a sequence back onto the stack. Every result
// carries the number of free blocks left after the request.
// Work is sequential: one request at a time. Open goes straight to the result.
// The other requests first run a restoring divide of the token position by
// tokens_per_block; then look up reads the page table, ensure pops blocks
// until the page is mapped and free visits each page held, all bounded by
// memories with separate write and read ports and registered reads.
// After reset a sweep over all NUM_BLOCKS (1024) entries rebuilds the free
// stack and clears the in-use marks and page counts; s_axis_tready stays low
// meanwhile, while the APB register port works as ever. A finished result
// sits in an output register, so the next request is accepted while the
// receiver stalls; a second result then waits until the first has been taken.
// tokens_per_block is written over APB at address 0 and should only change
// while the block is idle.
module paged_kv_block_manager
  import pkvbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] req_type, [7:2] seq_handle, [23:8] token_position
  input  logic [23:0] s_axis_tdata,
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [12:3] block_id, [18:13] new_handle, [29:19] blocks_free
  output logic [31:0] m_axis_tdata
);

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DIV    = 11'b00000000100,
    S_ENS    = 11'b00000001000,
    S_POP    = 11'b00000010000,
    S_LK     = 11'b00000100000,
    S_RES    = 11'b00001000000,
    S_FR     = 11'b00010000000,
    S_FR_PT  = 11'b00100000000,
    S_FR_IU  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [TPB_W-1:0] tpb_q, tpb_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [HG_W-1:0]  hg_q, hg_d;
  logic [BLK_W-1:0] sweep_q, sweep_d;

  logic [1:0]       req_q, req_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [POS_W-1:0] need_q, need_d;
  logic [PH_W-1:0]  ph_q, ph_d;
  logic [PH_W-1:0]  idx_q, idx_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [2:0]       rst_stat_q, rst_stat_d;
  logic [BLK_W-1:0] rblk_q, rblk_d;
  logic [SEQ_W-1:0] rhnd_q, rhnd_d;

  logic             ovalid_q, ovalid_d;
  logic [31:0]      odata_q, odata_d;

  // Free stack
  logic [BLK_W-1:0] stk_mem [NUM_BLOCKS];
  logic             stk_we, stk_re;
  logic [BLK_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  // In-use marks
  logic             iu_mem [NUM_BLOCKS];
  logic             iu_we, iu_re, iu_wdata, iu_rdata;
  logic [BLK_W-1:0] iu_waddr, iu_raddr;
  // Page table
  logic [BLK_W-1:0] pt_mem [MAX_SEQS*MAX_PAGES_PER_SEQ];
  logic             pt_we, pt_re;
  logic [PT_AW-1:0] pt_waddr, pt_raddr;
  logic [BLK_W-1:0] pt_wdata, pt_rdata;
  // Pages held per sequence
  logic [PH_W-1:0]  ph_mem [MAX_SEQS];
  logic             ph_we, ph_re;
  logic [SEQ_W-1:0] ph_waddr, ph_raddr;
  logic [PH_W-1:0]  ph_wdata, ph_rdata;

  logic             s_acc, m_acc, cfg_we, div_start;
  logic [1:0]       in_req;
  logic [SEQ_W-1:0] in_seq;
  logic [POS_W-1:0] in_pos;
  div_res_t         div_res;

  assign in_req = s_axis_tdata[1:0];
  assign in_seq = s_axis_tdata[2 +: SEQ_W];
  assign in_pos = s_axis_tdata[8 +: POS_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = ovalid_q && m_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // Register map: tokens_per_block at byte address 0.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-TPB_W){1'b0}}, tpb_q} : 32'd0;
  assign tpb_d  = cfg_we ? pwdata[TPB_W-1:0] : tpb_q;

  assign div_start = s_acc && (in_req != REQ_OPEN);

  pkvbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_pos),
    .divisor_i  (tpb_q),
    .res_o      (div_res)
  );

  always_comb begin
    state_d    = state_q;
    depth_d    = depth_q;
    hg_d       = hg_q;
    sweep_d    = sweep_q;
    req_d      = req_q;
    seq_d      = seq_q;
    need_d     = need_q;
    ph_d       = ph_q;
    idx_d      = idx_q;
    blk_d      = blk_q;
    rst_stat_d = rst_stat_q;
    rblk_d     = rblk_q;
    rhnd_d     = rhnd_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    odata_d    = odata_q;

    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
    stk_re = 1'b0; stk_raddr = BLK_W'(depth_q - CNT_W'(1));
    iu_we  = 1'b0; iu_waddr  = '0; iu_wdata  = 1'b0;
    iu_re  = 1'b0; iu_raddr  = pt_rdata;
    pt_we  = 1'b0; pt_waddr  = {seq_q, ph_q[PG_W-1:0]}; pt_wdata = stk_rdata;
    pt_re  = 1'b0; pt_raddr  = {seq_q, need_q[PG_W-1:0]};
    ph_we  = 1'b0; ph_waddr  = seq_q; ph_wdata = ph_q;
    ph_re  = 1'b0; ph_raddr  = in_seq;

    case (state_q)
      S_INIT: begin
        // Rebuild the stack in descending order and clear marks and counts.
        stk_we    = 1'b1;
        stk_waddr = sweep_q;
        stk_wdata = BLK_W'(NUM_BLOCKS - 1) - sweep_q;
        iu_we     = 1'b1;
        iu_waddr  = sweep_q;
        ph_we     = 1'b1;
        ph_waddr  = sweep_q[SEQ_W-1:0];
        ph_wdata  = '0;
        sweep_d   = sweep_q + BLK_W'(1);
        if (sweep_q == BLK_W'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          req_d  = in_req;
          seq_d  = in_seq;
          rblk_d = '0;
          rhnd_d = '0;
          if (in_req == REQ_OPEN) begin
            if (hg_q >= HG_W'(MAX_SEQS)) begin
              rst_stat_d = ST_SEQ_FULL;
            end else begin
              rst_stat_d = ST_OK;
              rhnd_d     = hg_q[SEQ_W-1:0];
              ph_we      = 1'b1;
              ph_waddr   = hg_q[SEQ_W-1:0];
              ph_wdata   = '0;
              hg_d       = hg_q + HG_W'(1);
            end
            state_d = S_OUT;
          end else begin
            ph_re   = 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          need_d = div_res.quotient;
          ph_d   = ph_rdata;
          idx_d  = '0;
          case (req_q)
            REQ_ENSURE: state_d = S_ENS;
            REQ_LOOKUP: state_d = S_LK;
            default:    state_d = S_FR;
          endcase
        end
      end
      S_ENS: begin
        if (need_q >= POS_W'(MAX_PAGES_PER_SEQ)) begin
          rst_stat_d = ST_PAGES_FULL;
          state_d    = S_OUT;
        end else if ({{(POS_W-PH_W){1'b0}}, ph_q} <= need_q) begin
          if (depth_q == '0) begin
            // Pages popped so far stay mapped.
            ph_we      = 1'b1;
            rst_stat_d = ST_POOL_EMPTY;
            state_d    = S_OUT;
          end else begin
            stk_re  = 1'b1;
            state_d = S_POP;
          end
        end else begin
          ph_we   = 1'b1;
          pt_re   = 1'b1;
          state_d = S_RES;
        end
      end
      S_POP: begin
        iu_we    = 1'b1;
        iu_waddr = stk_rdata;
        iu_wdata = 1'b1;
        pt_we    = 1'b1;
        ph_d     = ph_q + PH_W'(1);
        depth_d  = depth_q - CNT_W'(1);
        state_d  = S_ENS;
      end
      S_LK: begin
        if (need_q >= POS_W'(MAX_PAGES_PER_SEQ) ||
            need_q >= {{(POS_W-PH_W){1'b0}}, ph_q}) begin
          rst_stat_d = ST_NOT_MAPPED;
          state_d    = S_OUT;
        end else begin
          pt_re   = 1'b1;
          state_d = S_RES;
        end
      end
      S_RES: begin
        rst_stat_d = ST_OK;
        rblk_d     = pt_rdata;
        state_d    = S_OUT;
      end
      S_FR: begin
        pt_raddr = {seq_q, idx_q[PG_W-1:0]};
        if (idx_q < ph_q && idx_q < PH_W'(MAX_PAGES_PER_SEQ)) begin
          pt_re   = 1'b1;
          state_d = S_FR_PT;
        end else begin
          ph_we      = 1'b1;
          ph_wdata   = '0;
          rst_stat_d = ST_OK;
          state_d    = S_OUT;
        end
      end
      S_FR_PT: begin
        iu_re   = 1'b1;
        blk_d   = pt_rdata;
        state_d = S_FR_IU;
      end
      S_FR_IU: begin
        if (iu_rdata) begin
          iu_we    = 1'b1;
          iu_waddr = blk_q;
          if (depth_q < CNT_W'(NUM_BLOCKS)) begin
            stk_we    = 1'b1;
            stk_waddr = depth_q[BLK_W-1:0];
            stk_wdata = blk_q;
            depth_d   = depth_q + CNT_W'(1);
          end
        end
        idx_d   = idx_q + PH_W'(1);
        state_d = S_FR;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {2'b00, depth_q, rhnd_q, rblk_q, rst_stat_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (iu_we) iu_mem[iu_waddr] <= iu_wdata;
    if (iu_re) iu_rdata <= iu_mem[iu_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ph_we) ph_mem[ph_waddr] <= ph_wdata;
    if (ph_re) ph_rdata <= ph_mem[ph_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      tpb_q    <= TPB_W'(16);
      depth_q  <= CNT_W'(NUM_BLOCKS);
      hg_q     <= '0;
      sweep_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tpb_q    <= tpb_d;
      depth_q  <= depth_d;
      hg_q     <= hg_d;
      sweep_q  <= sweep_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    seq_q      <= seq_d;
    need_q     <= need_d;
    ph_q       <= ph_d;
    idx_q      <= idx_d;
    blk_q      <= blk_d;
    rst_stat_q <= rst_stat_d;
    rblk_q     <= rblk_d;
    rhnd_q     <= rhnd_d;
    odata_q    <= odata_d;
  end

  // The free count never exceeds the pool.
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CNT_W'(NUM_BLOCKS))
    else $error("free depth beyond pool size");

  // Each pop takes exactly one block off the stack.
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> depth_q == $past(depth_q) - CNT_W'(1))
    else $error("pop did not decrement free depth");

  // Handles given out never pass the sequence table size.
  a_hg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hg_q <= HG_W'(MAX_SEQS))
    else $error("handle count beyond sequence table");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && odata_q == $past(odata_q))
    else $error("result overwritten while stalled");

endmodule

FILE: tb/tb_paged_kv_block_manager.sv
module tb_paged_kv_block_manager;
  import pkvbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is abandoned. This covers
  // the free-stack sweep after reset, a full free of 64 pages and the
  // longest receiver stall, several times over.
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    req_e             kind;
    logic [SEQ_W-1:0] seq;
    logic [POS_W-1:0] pos;
  } kv_req_t;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] blk;
    logic [SEQ_W-1:0] handle;
    logic [CNT_W-1:0] free_cnt;
  } kv_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  paged_kv_block_manager i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the block: the free stack, in-use marks, page tables and the
  // handle counter, updated as each request transaction is accepted.
  logic [BLK_W-1:0] shadow_stack [NUM_BLOCKS];
  int unsigned      shadow_depth;
  bit               shadow_in_use [NUM_BLOCKS];
  logic [BLK_W-1:0] shadow_pages [MAX_SEQS*MAX_PAGES_PER_SEQ];
  int unsigned      shadow_held [MAX_SEQS];
  int unsigned      shadow_handles;
  int unsigned      shadow_tpb;

  kv_req_t     req_queue[$];
  kv_res_t     pending_results[$];
  int unsigned errors;
  int unsigned idle_cycles;
  bit          apb_busy;

  // Request field order on the stream: req_type in the lowest bits, then
  // seq_handle, then token_position.
  function automatic logic [23:0] pack_req(kv_req_t r);
    return {r.pos, r.seq, r.kind};
  endfunction

  function automatic kv_req_t unpack_req(logic [23:0] d);
    kv_req_t r;
    r.kind = req_e'(d[1:0]);
    r.seq  = d[2 +: SEQ_W];
    r.pos  = d[8 +: POS_W];
    return r;
  endfunction

  function automatic kv_res_t predict_kv_result(kv_req_t r);
    kv_res_t     res;
    int unsigned bs;
    int unsigned need;
    int unsigned base;
    int unsigned b;
    res = '{status: ST_OK, blk: '0, handle: '0, free_cnt: '0};
    bs = (shadow_tpb == 0) ? 1 : shadow_tpb;
    need = r.pos / bs;
    base = r.seq * MAX_PAGES_PER_SEQ;
    case (r.kind)
      REQ_OPEN: begin
        if (shadow_handles >= MAX_SEQS) begin
          res.status = ST_SEQ_FULL;
        end else begin
          shadow_held[shadow_handles] = 0;
          res.handle = shadow_handles[SEQ_W-1:0];
          shadow_handles++;
        end
      end
      REQ_ENSURE: begin
        if (need >= MAX_PAGES_PER_SEQ) begin
          res.status = ST_PAGES_FULL;
        end else begin
          while (shadow_held[r.seq] <= need && res.status == ST_OK) begin
            if (shadow_depth == 0) begin
              res.status = ST_POOL_EMPTY;
            end else begin
              shadow_depth--;
              b = shadow_stack[shadow_depth];
              shadow_in_use[b] = 1'b1;
              shadow_pages[base + shadow_held[r.seq]] = b[BLK_W-1:0];
              shadow_held[r.seq]++;
            end
          end
          if (res.status == ST_OK) res.blk = shadow_pages[base + need];
        end
      end
      REQ_LOOKUP: begin
        if (need >= shadow_held[r.seq] || need >= MAX_PAGES_PER_SEQ)
          res.status = ST_NOT_MAPPED;
        else
          res.blk = shadow_pages[base + need];
      end
      default: begin
        // Free: only blocks still marked in use go back onto the stack.
        for (int unsigned i = 0; i < shadow_held[r.seq] && i < MAX_PAGES_PER_SEQ; i++) begin
          b = shadow_pages[base + i];
          if (shadow_in_use[b]) begin
            shadow_in_use[b] = 1'b0;
            if (shadow_depth < NUM_BLOCKS) begin
              shadow_stack[shadow_depth] = b[BLK_W-1:0];
              shadow_depth++;
            end
          end
        end
        shadow_held[r.seq] = 0;
      end
    endcase
    res.free_cnt = shadow_depth[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: presents queued requests, drawing an idle gap after each
  // accepted transaction. A zero gap keeps tvalid high for the next request.
  int unsigned req_gap;
  bit          burst_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned g;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      req_gap       <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(predict_kv_result(unpack_req(s_axis_tdata)));
      g = burst_mode ? 0 : $urandom_range(0, 6);
      if (g == 0 && req_queue.size() > 0) begin
        s_axis_tdata <= pack_req(req_queue.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
        req_gap       <= g;
      end
    end else if (!s_axis_tvalid) begin
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
      end else if (req_queue.size() > 0) begin
        s_axis_tdata  <= pack_req(req_queue.pop_front());
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  // and stalls the result stream for a random number of cycles afterwards.
  int unsigned res_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    kv_res_t want;
    int unsigned s;
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
      res_stall     <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] != want.status)
          report_mismatch("status", m_axis_tdata[2:0], want.status);
        if (m_axis_tdata[12:3] != want.blk)
          report_mismatch("block_id", m_axis_tdata[12:3], want.blk);
        if (m_axis_tdata[18:13] != want.handle)
          report_mismatch("new_handle", m_axis_tdata[18:13], want.handle);
        if (m_axis_tdata[29:19] != want.free_cnt)
          report_mismatch("blocks_free", m_axis_tdata[29:19], want.free_cnt);
      end
      s = burst_mode ? 0 : $urandom_range(0, 6);
      if (s != 0) begin
        m_axis_tready <= 1'b0;
        res_stall     <= s;
      end
    end else if (!m_axis_tready) begin
      if (res_stall <= 1) m_axis_tready <= 1'b1;
      res_stall <= res_stall - 1;
    end
  end

  // Watchdog: any transaction on either stream or the APB port restarts it.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || apb_busy)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[paged_kv_block_manager] ERROR");
      $finish;
    end
  end

  // Writes tokens_per_block with a setup and an access cycle, then reads it
  // back the same way.
  task automatic write_block_size(int unsigned value);
    apb_busy <= 1'b1;
    psel     <= 1'b1;
    pwrite   <= 1'b1;
    paddr    <= 3'd0;
    pwdata   <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_tpb = value & 32'h1FF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[TPB_W-1:0] != shadow_tpb[TPB_W-1:0])
      report_mismatch("tokens_per_block read", prdata[TPB_W-1:0], shadow_tpb);
    psel     <= 1'b0;
    penable  <= 1'b0;
    apb_busy <= 1'b0;
  endtask

  int unsigned opens_issued;

  function automatic kv_req_t random_request(int unsigned bs);
    kv_req_t     r;
    int unsigned pick;
    int unsigned page;
    int unsigned p;
    pick = $urandom_range(0, 99);
    if (pick < 7)       r.kind = REQ_OPEN;
    else if (pick < 55) r.kind = REQ_ENSURE;
    else if (pick < 85) r.kind = REQ_LOOKUP;
    else                r.kind = REQ_FREE;
    if (r.kind == REQ_OPEN) opens_issued++;
    // Mostly handles already opened, now and then any handle at all.
    if (opens_issued > 0 && $urandom_range(0, 9) != 0)
      r.seq = SEQ_W'($urandom_range(0,
                (opens_issued > MAX_SEQS ? MAX_SEQS : opens_issued) - 1));
    else
      r.seq = SEQ_W'($urandom());
    if ($urandom_range(0, 9) == 0) begin
      r.pos = POS_W'($urandom());
    end else begin
      page = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 80) : $urandom_range(0, 63);
      p = page * bs + $urandom_range(0, bs - 1);
      r.pos = (p > 65535) ? POS_W'($urandom()) : p[POS_W-1:0];
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (req_queue.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  int unsigned block_sizes [6] = '{16, 1, 0, 256, 511, 5};

  initial begin
    int unsigned bs;
    errors         = 0;
    idle_cycles    = 0;
    apb_busy       = 1'b0;
    burst_mode     = 1'b0;
    opens_issued   = 0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b1;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      shadow_stack[i]  = BLK_W'(NUM_BLOCKS - 1 - i);
      shadow_in_use[i] = 1'b0;
    end
    foreach (shadow_pages[i]) shadow_pages[i] = '0;
    foreach (shadow_held[i]) shadow_held[i] = 0;
    shadow_depth   = NUM_BLOCKS;
    shadow_handles = 0;
    shadow_tpb     = 16;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (block_sizes[k]) begin
      write_block_size(block_sizes[k]);
      bs = (shadow_tpb == 0) ? 1 : shadow_tpb;
      if (k == 0) begin
        // Directed requests: page list overflow, a full 64-page ensure,
        // hits and misses, unopened handles and repeated frees.
        req_queue.push_back('{REQ_OPEN, 6'd0, 16'd0});
        req_queue.push_back('{REQ_OPEN, 6'h3F, 16'hFFFF});
        req_queue.push_back('{REQ_ENSURE, 6'd0, 16'd0});
        req_queue.push_back('{REQ_ENSURE, 6'd0, 16'hFFFF});
        req_queue.push_back('{REQ_ENSURE, 6'd1, 16'd1023});
        req_queue.push_back('{REQ_LOOKUP, 6'd1, 16'd0});
        req_queue.push_back('{REQ_LOOKUP, 6'd1, 16'd1023});
        req_queue.push_back('{REQ_LOOKUP, 6'd1, 16'd1024});
        req_queue.push_back('{REQ_LOOKUP, 6'd0, 16'd16});
        req_queue.push_back('{REQ_LOOKUP, 6'h3F, 16'd0});
        req_queue.push_back('{REQ_ENSURE, 6'h3F, 16'd5});
        req_queue.push_back('{REQ_FREE, 6'd1, 16'd0});
        req_queue.push_back('{REQ_FREE, 6'd1, 16'hFFFF});
        req_queue.push_back('{REQ_LOOKUP, 6'd1, 16'd0});
        req_queue.push_back('{REQ_FREE, 6'h3F, 16'd0});
        req_queue.push_back('{REQ_FREE, 6'h2A, 16'd0});
        opens_issued = 2;
      end
      // Switch at random between stretches with random idling and back-to-back
      // stretches, in chunks so that the two modes change mid-phase.
      for (int c = 0; c < 7; c++) begin
        for (int n = 0; n < 20; n++) req_queue.push_back(random_request(bs));
        while (req_queue.size() > 0) @(posedge clk_i);
        burst_mode <= ($urandom_range(0, 3) == 0);
      end
      wait_idle();
      burst_mode <= 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[paged_kv_block_manager] OK");
    end else begin
      $display("[paged_kv_block_manager] ERROR");
    end
    $finish;
  end

endmodule

FILE: paged_kv_block_manager.f
rtl/pkvbm_pkg.sv
rtl/pkvbm_div.sv
rtl/paged_kv_block_manager.sv
tb/tb_paged_kv_block_manager.sv
